[hw/rtl/sefe_pkg.sv]
`default_nettype none
package sefe_pkg;

    localparam int MantW = 24;
    localparam int ExpW = 9;
    localparam logic signed [ExpW-1:0] ExpFloor = -9'sd128;
    localparam logic [4:0] MantBitsReset = 5'd16;
    localparam int QueueDepthDefault = 2;

    typedef enum logic [1:0] {
        t_func_scan    = 2'd0,
        t_func_running = 2'd1,
        t_func_shared  = 2'd2,
        t_func_own     = 2'd3
    } t_func;

    typedef struct packed {
        logic                   neg;
        logic [23:0]            mag;
        logic signed [ExpW-1:0] e;
        logic signed [ExpW-1:0] q;
    } t_dec;

    typedef struct packed {
        t_dec                   d;
        logic signed [ExpW:0]   x;
    } t_lane;

    typedef struct packed {
        t_lane lx;
        t_lane ly;
        t_lane lz;
    } t_job;

    function automatic t_dec decode(input logic [31:0] w);
        t_dec d;
        logic [7:0] bexp;
        logic [22:0] frac;
        logic [4:0] bl;
        bexp = w[30:23];
        frac = w[22:0];
        d.neg = w[31];
        bl = 5'd0;
        for (int i = 0; i < 23; i++) begin
            if (frac[i]) begin
                bl = 5'(i + 1);
            end
        end
        if (bexp == 8'd0) begin
            d.mag = {1'b0, frac};
            d.q = -9'sd149;
            d.e = (frac == 23'd0) ? 9'sd0 : ($signed({4'd0, bl}) - 9'sd149);
        end else begin
            d.mag = {1'b1, frac};
            d.q = $signed({1'b0, bexp}) - 9'sd150;
            d.e = $signed({1'b0, bexp}) - 9'sd126;
        end
        return d;
    endfunction

    function automatic logic [31:0] pack(input t_lane l);
        logic signed [ExpW+1:0] sh;
        logic [24:0] m;
        logic [64:0] ext;
        logic [5:0] r;
        sh = 11'(l.d.q) - 11'(l.x);
        m = '0;
        ext = '0;
        r = '0;
        if (l.d.mag != 24'd0) begin
            if (sh >= 0) begin
                m = (sh >= 24) ? 25'd0 : 25'({l.d.mag, 24'd0} >> (6'd24 - 6'(sh)));
            end else if (sh >= -40) begin
                r = 6'(-sh);
                ext = ({41'd0, l.d.mag} + (65'd1 << (r - 6'd1))) >> r;
                m = ext[24:0];
            end
            if (l.d.neg) begin
                m = 25'd0 - m;
            end
        end
        return {l.x[7:0], m[23:0]};
    endfunction

endpackage
`default_nettype wire

[hw/rtl/sefe_front.sv]
`default_nettype none
module sefe_front
    import sefe_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [4:0]  i_cfg_data,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_valid,
    input  wire logic [1:0]  i_func,
    input  wire logic        i_restart,
    input  wire logic [31:0] i_value_x,
    input  wire logic [31:0] i_value_y,
    input  wire logic [31:0] i_value_z,
    input  wire logic        i_q_full,
    output logic             o_stall,
    output logic             o_push,
    output t_job             o_job
);
    logic [4:0] r_kbits;
    logic signed [ExpW-1:0] r_max [3];
    logic signed [ExpW-1:0] n_max [3];
    t_dec dx, dy, dz;
    logic signed [ExpW-1:0] mx, base [3];
    logic signed [ExpW:0] lower;
    logic acc;
    t_func fn;

    assign fn = t_func'(i_func);
    assign o_stall = i_q_full;
    assign acc = i_valid && !i_q_full;
    assign o_push = acc && (fn != t_func_scan);
    assign dx = decode(i_value_x);
    assign dy = decode(i_value_y);
    assign dz = decode(i_value_z);
    assign lower = $signed({5'd0, r_kbits}) - 10'sd1;

    always_comb begin
        mx = dx.e;
        if (dy.e > mx) mx = dy.e;
        if (dz.e > mx) mx = dz.e;
        unique case (fn)
            t_func_running: begin
                base[0] = r_max[0]; base[1] = r_max[1]; base[2] = r_max[2];
            end
            t_func_shared: begin
                base[0] = mx; base[1] = mx; base[2] = mx;
            end
            default: begin
                base[0] = dx.e; base[1] = dy.e; base[2] = dz.e;
            end
        endcase
        o_job.lx.d = dx;
        o_job.ly.d = dy;
        o_job.lz.d = dz;
        o_job.lx.x = 10'(base[0]) - lower;
        o_job.ly.x = 10'(base[1]) - lower;
        o_job.lz.x = 10'(base[2]) - lower;
    end

    always_comb begin
        logic signed [ExpW-1:0] es [3];
        es[0] = dx.e; es[1] = dy.e; es[2] = dz.e;
        for (int i = 0; i < 3; i++) begin
            n_max[i] = i_restart ? ExpFloor : r_max[i];
            if (es[i] > n_max[i]) n_max[i] = es[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kbits <= MantBitsReset;
            for (int i = 0; i < 3; i++) r_max[i] <= ExpFloor;
        end else begin
            if (i_cfg_valid) r_kbits <= i_cfg_data;
            if (acc && fn == t_func_scan) begin
                for (int i = 0; i < 3; i++) r_max[i] <= n_max[i];
            end
        end
    end
endmodule
`default_nettype wire

[hw/rtl/sefe_queue.sv]
`default_nettype none
module sefe_queue
    import sefe_pkg::*;
#(
    parameter int Depth = QueueDepthDefault
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_job      i_job,
    output logic      o_full,
    output logic      o_valid,
    output t_job      o_job,
    input  wire logic i_pop
);
    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
    t_job r_mem [Depth];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0] r_cnt;
    logic do_pop, do_push;

    assign o_valid = r_cnt != '0;
    assign o_full = r_cnt == (AW+1)'(Depth);
    assign o_job = r_mem[r_rp];
    assign do_pop = i_pop && o_valid;
    assign do_push = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= (r_wp == AW'(Depth - 1)) ? '0 : r_wp + 1'b1;
            if (do_pop) r_rp <= (r_rp == AW'(Depth - 1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end
endmodule
`default_nettype wire

[hw/rtl/sefe_back.sv]
`default_nettype none
module sefe_back
    import sefe_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    input  t_job        i_job,
    output logic        o_pop,
    output logic        o_valid,
    output logic [31:0] o_word_x,
    output logic [31:0] o_word_y,
    output logic [31:0] o_word_z,
    input  wire logic   i_stall
);
    logic r_valid;
    logic load;

    assign load = i_valid && (!r_valid || !i_stall);
    assign o_pop = load;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            o_word_x <= pack(i_job.lx);
            o_word_y <= pack(i_job.ly);
            o_word_z <= pack(i_job.lz);
        end
    end
endmodule
`default_nettype wire

[hw/rtl/shared_exponent_float_encode_unit.sv]
// an accepted item goes into the queue, then into the output register once that is free
// one item per cycle unless the queue is full; scan items update the maxima and give no result
// a two-entry queue decouples decode from the rounding shift stage; a full queue stalls input
// reset: synchronous active low; maxima return to -128, mantissa_bits to 16,
// queue and output register empty
`default_nettype none
module shared_exponent_float_encode_unit
    import sefe_pkg::*;
#(
    parameter int QueueDepth = QueueDepthDefault
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [4:0]  i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_func,
    input  wire logic        i_restart,
    input  wire logic [31:0] i_value_x,
    input  wire logic [31:0] i_value_y,
    input  wire logic [31:0] i_value_z,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_word_x,
    output logic [31:0]      o_word_y,
    output logic [31:0]      o_word_z
);
    logic q_full, push, q_valid, pop;
    t_job fjob, qjob;

    assign o_cfg_ready = 1'b1;

    sefe_front u_front (
        .i_clk, .i_rst_n, .i_cfg_data, .i_cfg_valid, .i_valid, .i_func, .i_restart,
        .i_value_x, .i_value_y, .i_value_z, .i_q_full(q_full), .o_stall,
        .o_push(push), .o_job(fjob)
    );

    sefe_queue #(.Depth(QueueDepth)) u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_job(fjob), .o_full(q_full),
        .o_valid(q_valid), .o_job(qjob), .i_pop(pop)
    );

    sefe_back u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .i_job(qjob), .o_pop(pop), .o_valid,
        .o_word_x, .o_word_y, .o_word_z, .i_stall
    );
endmodule
`default_nettype wire

[hw/rtl/sefe_checker.sv]
`default_nettype none
module sefe_props (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [31:0] o_word_x,
    input wire logic        o_cfg_ready
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_word_x))
        else $error("result dropped while stalled");
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result after reset");
    a_cfg_ready: assert property (@(posedge i_clk) o_cfg_ready)
        else $error("cfg not ready");
    a_no_stall_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid && $past(!o_valid) && $past(!i_valid) |-> !o_stall)
        else $error("stall with empty pipe");
endmodule

bind shared_exponent_float_encode_unit sefe_props u_chk (
    .i_clk, .i_rst_n, .i_valid, .o_stall, .o_valid, .i_stall, .o_word_x, .o_cfg_ready
);
`default_nettype wire
